FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the boundary extractor RTL.
// Depends on nothing; taken in by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define VLBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define VLBE_NEVER(label, clk, rst, cond, msg) \
   `VLBE_ASSERT(label, clk, rst, !(cond), msg)

`endif

FILE: hw/rtl/vlbe_pkg.sv
// Shared constants, types and helpers of the voxel boundary extractor.
// No dependencies.
package vlbe_pkg;

   localparam int MAX_GRID_DEFAULT   = 64;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int LABEL_BITS         = 8;
   localparam int GRID_BITS          = 7;
   localparam logic [GRID_BITS-1:0] GRID_RESET = 7'd64;
   localparam int GRID_MIN           = 2;
   localparam int PAIR_ID_BITS       = 15;
   localparam int INDEX_BITS         = 20;
   localparam int AXIS_BITS          = 2;
   localparam int PAIR_SCALE         = 100;
   localparam int QUEUE_DEPTH        = 4;

   typedef enum logic [AXIS_BITS-1:0] {
      AXIS_I = 2'd0,
      AXIS_J = 2'd1,
      AXIS_K = 2'd2
   } axis_type;

   // per queued voxel: which forward pairs differ, and end-of-volume mark
   typedef struct packed {
      logic       vol_end;
      logic [2:0] diff;    // bit0 +i, bit1 +j, bit2 +k
   } entry_ctl_type;

   function automatic logic [PAIR_ID_BITS-1:0] pair_id(
      input logic [LABEL_BITS-1:0] a,
      input logic [LABEL_BITS-1:0] b
   );
      logic [LABEL_BITS-1:0] lo;
      logic [LABEL_BITS-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return PAIR_ID_BITS'(PAIR_ID_BITS'(lo) * PAIR_ID_BITS'(PAIR_SCALE))
             + PAIR_ID_BITS'(hi);
   endfunction

endpackage

FILE: hw/rtl/vlbe_front.sv
// Front end: voxel intake, raster position, previous-plane buffer, pair classification.
// Depends on vlbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vlbe_front #(
   parameter int MAX_GRID   = vlbe_pkg::MAX_GRID_DEFAULT,
   parameter int COORD_BITS = vlbe_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [$clog2(MAX_GRID+1)-1:0] eff_grid,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vlbe_pkg::LABEL_BITS+3*COORD_BITS-1:0] req_word,
   output logic                          push_valid,
   output vlbe_pkg::entry_ctl_type       push_ctl,
   output logic [4*(vlbe_pkg::LABEL_BITS+3*COORD_BITS)-1:0] push_data,
   input  logic                          queue_full
);

   localparam int GW = $clog2(MAX_GRID+1);
   localparam int PW = $clog2(MAX_GRID);
   localparam int AW = $clog2(MAX_GRID*MAX_GRID);
   localparam int MW = vlbe_pkg::LABEL_BITS + 3*COORD_BITS;
   localparam int LB = vlbe_pkg::LABEL_BITS;
   localparam int PLANE_DEPTH = MAX_GRID*MAX_GRID;

   logic [PW-1:0] pos_i_ff, pos_i_in;
   logic [PW-1:0] pos_j_ff, pos_j_in;
   logic [PW-1:0] pos_k_ff, pos_k_in;
   logic [AW-1:0] here_ff, here_in;
   logic [AW-1:0] here_next;
   logic [AW-1:0] addr_j;
   logic          accept;
   logic          i_end, j_end, k_end;
   logic [GW-1:0] grid_last;

   logic [MW-1:0] plane_mem [PLANE_DEPTH];
   logic [MW-1:0] rd_a_ff;     // entry at the next position (+k neighbour)
   logic [MW-1:0] rd_b_ff;     // entry one row on (+j neighbour)
   logic [MW-1:0] base_ff;     // entry at this position, read by the voxel before
   logic [MW-1:0] s1_cur_ff;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_pair_ok_ff, s1_pair_ok_in;
   logic          s1_vol_end_ff, s1_vol_end_in;
   logic          push_needed;
   logic          s1_advance;
   logic [2:0]    diff;

   assign accept    = req_tvalid && req_tready;
   assign grid_last = eff_grid - GW'(1);
   assign i_end     = (GW'(pos_i_ff) == grid_last);
   assign j_end     = (GW'(pos_j_ff) == grid_last);
   assign k_end     = (GW'(pos_k_ff) == grid_last);
   assign here_next = (j_end && k_end) ? '0 : here_ff + AW'(1);
   assign addr_j    = AW'({1'b0, here_ff} + (AW+1)'(eff_grid));

   always_comb begin
      pos_i_in = pos_i_ff;
      pos_j_in = pos_j_ff;
      pos_k_in = pos_k_ff;
      here_in  = here_ff;
      if (restart) begin
         pos_i_in = '0;
         pos_j_in = '0;
         pos_k_in = '0;
         here_in  = '0;
      end else if (accept) begin
         here_in = here_next;
         if (!k_end) begin
            pos_k_in = pos_k_ff + PW'(1);
         end else begin
            pos_k_in = '0;
            if (!j_end) begin
               pos_j_in = pos_j_ff + PW'(1);
            end else begin
               pos_j_in = '0;
               pos_i_in = i_end ? '0 : pos_i_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_i_ff <= '0;
         pos_j_ff <= '0;
         pos_k_ff <= '0;
         here_ff  <= '0;
      end else begin
         pos_i_ff <= pos_i_in;
         pos_j_ff <= pos_j_in;
         pos_k_ff <= pos_k_in;
         here_ff  <= here_in;
      end
   end

   // two reads and one write per voxel; reads see the previous plane
   always_ff @(posedge clock) begin
      if (accept) begin
         plane_mem[here_ff] <= req_word;
         rd_a_ff            <= plane_mem[here_next];
         rd_b_ff            <= plane_mem[addr_j];
         base_ff            <= rd_a_ff;
         s1_cur_ff          <= req_word;
      end
   end

   always_comb begin
      diff = '0;
      if (s1_pair_ok_ff) begin
         diff[0] = (base_ff[LB-1:0] != s1_cur_ff[LB-1:0]);
         diff[1] = (base_ff[LB-1:0] != rd_b_ff[LB-1:0]);
         diff[2] = (base_ff[LB-1:0] != rd_a_ff[LB-1:0]);
      end
   end

   assign push_needed = s1_valid_ff && ((diff != '0) || s1_vol_end_ff);
   assign push_valid  = push_needed && !queue_full;
   assign s1_advance  = !s1_valid_ff || !push_needed || !queue_full;
   assign req_tready  = s1_advance;

   assign push_ctl.vol_end = s1_vol_end_ff;
   assign push_ctl.diff    = diff;
   assign push_data        = {rd_a_ff, rd_b_ff, s1_cur_ff, base_ff};

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_pair_ok_in = s1_pair_ok_ff;
      s1_vol_end_in = s1_vol_end_ff;
      if (accept) begin
         s1_valid_in   = 1'b1;
         s1_pair_ok_in = (pos_i_ff != '0) && !j_end && !k_end;
         s1_vol_end_in = i_end && j_end && k_end;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_pair_ok_ff <= 1'b0;
         s1_vol_end_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s1_pair_ok_ff <= s1_pair_ok_in;
         s1_vol_end_ff <= s1_vol_end_in;
      end
   end

   `VLBE_ASSERT(a_pos_in_grid, clock, reset,
      (GW'(pos_k_ff) < eff_grid) && (GW'(pos_j_ff) < eff_grid),
      "raster position outside the grid")

endmodule

FILE: hw/rtl/vlbe_queue.sv
// Short register queue between the front end and the result sequencer.
// Depends on vlbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vlbe_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int DEPTH = vlbe_pkg::QUEUE_DEPTH;
   localparam int PTRW  = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTRW'(wr_ptr_ff + PTRW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTRW'(rd_ptr_ff + PTRW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `VLBE_NEVER(a_no_overflow, clock, reset, push && full,
      "transfer into a full queue")
   `VLBE_NEVER(a_no_underflow, clock, reset, pop && empty,
      "pop from an empty queue")

endmodule

FILE: hw/rtl/vlbe_back.sv
// Back end: walks the differing pairs of each queued voxel and drives the result register.
// Depends on vlbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vlbe_back #(
   parameter int COORD_BITS = vlbe_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          head_valid,
   input  vlbe_pkg::entry_ctl_type       head_ctl,
   input  logic [4*(vlbe_pkg::LABEL_BITS+3*COORD_BITS)-1:0] head_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [((3*(COORD_BITS+1)+2*vlbe_pkg::LABEL_BITS+vlbe_pkg::PAIR_ID_BITS
                   +vlbe_pkg::INDEX_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic [vlbe_pkg::AXIS_BITS-1:0] rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int LB = vlbe_pkg::LABEL_BITS;
   localparam int MW = LB + 3*COORD_BITS;
   localparam int SW = COORD_BITS + 1;
   localparam int IW = vlbe_pkg::INDEX_BITS;
   localparam int PB = vlbe_pkg::PAIR_ID_BITS;
   localparam int RSP_BITS = ((3*SW + 2*LB + PB + IW + 7)/8)*8;

   logic [2:0]          sent_ff, sent_in;
   logic [2:0]          remain;
   logic [2:0]          sel;
   logic [2:0]          remain_after;
   logic                out_free;
   logic                fire;
   vlbe_pkg::axis_type  axis;
   logic [MW-1:0]       first_word;
   logic [MW-1:0]       second_word;
   logic [IW-1:0]       count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]       mid_x_ff, mid_y_ff, mid_z_ff;
   logic [SW-1:0]       mid_sum [3];
   logic [LB-1:0]       first_ff, second_ff;
   logic [PB-1:0]       pair_ff;
   logic [IW-1:0]       index_ff;
   vlbe_pkg::axis_type  axis_ff;
   logic                last_ff;

   assign remain = head_valid ? (head_ctl.diff & ~sent_ff) : '0;

   // lowest outstanding pair goes first: +i, then +j, then +k
   always_comb begin
      if (remain[0]) begin
         axis = vlbe_pkg::AXIS_I;
         sel  = 3'b001;
      end else if (remain[1]) begin
         axis = vlbe_pkg::AXIS_J;
         sel  = 3'b010;
      end else begin
         axis = vlbe_pkg::AXIS_K;
         sel  = 3'b100;
      end
   end

   assign remain_after = remain & ~sel;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign fire         = head_valid && out_free && (remain != '0);
   assign pop          = head_valid && ((remain == '0) || (fire && (remain_after == '0)));

   assign first_word = head_data[MW-1:0];

   always_comb begin
      unique case (axis)
         vlbe_pkg::AXIS_I: second_word = head_data[2*MW-1:MW];
         vlbe_pkg::AXIS_J: second_word = head_data[3*MW-1:2*MW];
         vlbe_pkg::AXIS_K: second_word = head_data[4*MW-1:3*MW];
         default:          second_word = head_data[4*MW-1:3*MW];
      endcase
   end

   for (genvar c = 0; c < 3; c++) begin : g_mid
      logic [COORD_BITS-1:0] ca, cb;
      assign ca = first_word[LB + c*COORD_BITS +: COORD_BITS];
      assign cb = second_word[LB + c*COORD_BITS +: COORD_BITS];
      assign mid_sum[c] = {ca[COORD_BITS-1], ca} + {cb[COORD_BITS-1], cb};
   end

   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = '0;
      end else if (fire) begin
         sent_in = sent_ff | sel;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (restart) begin
         count_in = '0;
      end else if (pop && head_ctl.vol_end) begin
         count_in = '0;
      end else if (fire) begin
         count_in = count_ff + IW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mid_x_ff  <= mid_sum[0];
         mid_y_ff  <= mid_sum[1];
         mid_z_ff  <= mid_sum[2];
         first_ff  <= first_word[LB-1:0];
         second_ff <= second_word[LB-1:0];
         pair_ff   <= vlbe_pkg::pair_id(first_word[LB-1:0], second_word[LB-1:0]);
         index_ff  <= count_ff;
         axis_ff   <= axis;
         last_ff   <= (remain_after == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({index_ff, pair_ff, second_ff, first_ff,
                                  mid_z_ff, mid_y_ff, mid_x_ff});
   assign rsp_tuser  = axis_ff;
   assign rsp_tlast  = last_ff;

   // a result that does not close its run leaves work on the head entry
   `VLBE_ASSERT(a_run_continues, clock, reset,
      (rsp_valid_ff && !last_ff) |-> (head_valid && (remain != '0)),
      "run ended without a closing result")

endmodule

FILE: hw/rtl/voxel_label_boundary_extract.sv
// Voxel label boundary extractor, top level: grid size register, front end, queue, back end.
// Depends on vlbe_pkg, vlbe_front, vlbe_queue and vlbe_back.

// Voxels arrive in raster order (k fastest, then j, then i) on the req_ stream and each
// forward neighbour pair (+i, +j, +k) whose labels differ yields one boundary point on the
// rsp_ stream, tlast on the last point of a voxel; none when the lower voxel is on the last
// j row or k column. The front end takes one voxel per cycle while the queue has room: the
// previous-plane buffer is one memory with one write and two read ports, and the +k
// neighbour of one voxel is the buffer entry the next voxel starts from. Points leave at one
// per cycle from the output register while rsp_tready allows, so the output register sets
// the pace; a four-entry queue lets the intake run ahead while points drain. Writing
// csr_write_data restarts the volume at position zero with the point count cleared; sizes
// below 2 act as 2 and above MAX_GRID as MAX_GRID. No clearing pass after reset.
module voxel_label_boundary_extract #(
   parameter int MAX_GRID   = vlbe_pkg::MAX_GRID_DEFAULT,
   parameter int COORD_BITS = vlbe_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic [vlbe_pkg::GRID_BITS-1:0] csr_write_data,   // grid_size
   input  logic req_tvalid,
   output logic req_tready,
   // grain_label, coord_x, coord_y, coord_z (lowest first)
   input  logic [((vlbe_pkg::LABEL_BITS+3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // mid_x, mid_y, mid_z, grain_first, grain_second, pair_id, boundary_index (lowest first)
   output logic [((3*(COORD_BITS+1)+2*vlbe_pkg::LABEL_BITS+vlbe_pkg::PAIR_ID_BITS
                   +vlbe_pkg::INDEX_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic [vlbe_pkg::AXIS_BITS-1:0] rsp_tuser,           // neighbour_axis
   output logic rsp_tlast                                      // last_of_run
);

   localparam int GW = $clog2(MAX_GRID+1);
   localparam int MW = vlbe_pkg::LABEL_BITS + 3*COORD_BITS;
   localparam int CTLW = $bits(vlbe_pkg::entry_ctl_type);
   localparam int QW = 4*MW + CTLW;

   logic [vlbe_pkg::GRID_BITS-1:0] grid_size_ff, grid_size_in;
   logic [GW-1:0]                  eff_grid;

   logic                    push_valid;
   vlbe_pkg::entry_ctl_type push_ctl;
   logic [4*MW-1:0]         push_data;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    pop;
   logic [QW-1:0]           head_word;
   vlbe_pkg::entry_ctl_type head_ctl;

   assign grid_size_in = csr_write_en ? csr_write_data : grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= vlbe_pkg::GRID_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   always_comb begin
      if (int'(grid_size_ff) < vlbe_pkg::GRID_MIN) begin
         eff_grid = GW'(vlbe_pkg::GRID_MIN);
      end else if (int'(grid_size_ff) > MAX_GRID) begin
         eff_grid = GW'(MAX_GRID);
      end else begin
         eff_grid = GW'(grid_size_ff);
      end
   end

   vlbe_front #(
      .MAX_GRID   (MAX_GRID),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_en),
      .eff_grid   (eff_grid),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_tdata[MW-1:0]),
      .push_valid (push_valid),
      .push_ctl   (push_ctl),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   vlbe_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_data, push_ctl}),
      .full      (queue_full),
      .pop       (pop),
      .head_data (head_word),
      .empty     (queue_empty)
   );

   assign head_ctl = vlbe_pkg::entry_ctl_type'(head_word[CTLW-1:0]);

   vlbe_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_en),
      .head_valid (!queue_empty),
      .head_ctl   (head_ctl),
      .head_data  (head_word[QW-1:CTLW]),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
